### design/drse_pkg.sv
// Shared types and constants for the dirty rectangle set engine.
// No dependencies; imported by the sequencer, the datapath and the top level.
`default_nettype none
package drse_pkg;

  localparam int CAPACITY_DEF      = 32;
  localparam int PENDING_DEPTH_DEF = 32;
  localparam int COORD_BITS_DEF    = 16;
  localparam int MODE_BITS         = 3;
  localparam logic [1:0] PIECE_LAST = 2'd3;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ADD    = 3'd0,
    MODE_SUB    = 3'd1,
    MODE_CLIP   = 3'd2,
    MODE_BOUNDS = 3'd3,
    MODE_READ   = 3'd4,
    MODE_REMOVE = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ADD_CHK, S_ADD_EVAL, S_POP_LOAD, S_SUB_CHK, S_SUB_EVAL,
    S_SUB_PIECE, S_CLIP_CHK, S_CLIP_EVAL, S_BND_CHK, S_BND_EVAL, S_READ_WAIT,
    S_RM_RD, S_RM_WR, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    ACT_SKIP, ACT_DROP, ACT_REMOVE, ACT_TRIM, ACT_NEXT, ACT_DESCEND
  } add_act_t;

  typedef struct packed {
    logic load;
    logic start_add;
    logic clr_i;
    logic idx_to_i;
    logic set_found;
    logic rd_i;
    logic rd_idx;
    logic rd_last;
    logic wr_rm;
    logic add_eval;
    logic push_cur;
    logic pop_rd;
    logic pop_load;
    logic inc_i;
    logic sub_piece;
    logic clip_wr;
    logic bnd_acc;
    logic read_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic     op_empty;
    logic     i_end;
    logic     idx_ok;
    logic     top_zero;
    logic     count_zero;
    add_act_t act;
    logic     ovl;
    logic     cov;
    logic     k_last;
  } status_t;

endpackage
`default_nettype wire

### design/drse_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module drse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/drse_ctrl.sv
// Sequencer for the dirty rectangle set engine: walks the store per mode.
// Depends on drse_pkg; drives the datapath through cmd_t, reads status_t.
`default_nettype none
module drse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  drse_pkg::status_t status,
  output drse_pkg::cmd_t    cmd
);
  import drse_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.out_load | (out_valid & ~out_ready);
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        state_next = S_FIN;
        case (status.mode)
          MODE_ADD: begin
            if (!status.op_empty) begin
              cmd.start_add = 1'b1;
              state_next    = S_ADD_CHK;
            end
          end
          MODE_SUB: begin
            if (!status.op_empty) begin
              cmd.clr_i  = 1'b1;
              state_next = S_SUB_CHK;
            end
          end
          MODE_CLIP: begin
            cmd.clr_i  = 1'b1;
            state_next = S_CLIP_CHK;
          end
          MODE_BOUNDS: begin
            if (!status.count_zero) begin
              cmd.clr_i     = 1'b1;
              cmd.set_found = 1'b1;
              state_next    = S_BND_CHK;
            end
          end
          MODE_READ: begin
            if (status.idx_ok) begin
              cmd.rd_idx = 1'b1;
              state_next = S_READ_WAIT;
            end
          end
          MODE_REMOVE: begin
            if (status.idx_ok) begin
              cmd.idx_to_i  = 1'b1;
              cmd.set_found = 1'b1;
              state_next    = S_RM_RD;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_ADD_CHK: begin
        if (status.i_end) begin
          cmd.push_cur = 1'b1;
          if (status.top_zero) begin
            state_next = S_FIN;
          end else begin
            cmd.pop_rd = 1'b1;
            state_next = S_POP_LOAD;
          end
        end else begin
          cmd.rd_i   = 1'b1;
          state_next = S_ADD_EVAL;
        end
      end
      S_ADD_EVAL: begin
        cmd.add_eval = 1'b1;
        case (status.act)
          ACT_DROP: begin
            if (status.top_zero) begin
              state_next = S_FIN;
            end else begin
              cmd.pop_rd = 1'b1;
              state_next = S_POP_LOAD;
            end
          end
          ACT_REMOVE: state_next = S_RM_RD;
          default:    state_next = S_ADD_CHK;
        endcase
      end
      S_POP_LOAD: begin
        cmd.pop_load = 1'b1;
        state_next   = S_ADD_CHK;
      end
      S_SUB_CHK: begin
        if (status.i_end) begin
          state_next = S_FIN;
        end else begin
          cmd.rd_i   = 1'b1;
          state_next = S_SUB_EVAL;
        end
      end
      S_SUB_EVAL: begin
        if (!status.ovl) begin
          cmd.inc_i  = 1'b1;
          state_next = S_SUB_CHK;
        end else if (status.cov) begin
          state_next = S_RM_RD;
        end else begin
          state_next = S_SUB_PIECE;
        end
      end
      S_SUB_PIECE: begin
        cmd.sub_piece = 1'b1;
        if (status.k_last) begin
          state_next = S_RM_RD;
        end
      end
      S_CLIP_CHK: begin
        if (status.i_end) begin
          state_next = S_FIN;
        end else begin
          cmd.rd_i   = 1'b1;
          state_next = S_CLIP_EVAL;
        end
      end
      S_CLIP_EVAL: begin
        if (status.ovl) begin
          cmd.clip_wr = 1'b1;
          state_next  = S_CLIP_CHK;
        end else begin
          state_next = S_RM_RD;
        end
      end
      S_BND_CHK: begin
        if (status.i_end) begin
          state_next = S_FIN;
        end else begin
          cmd.rd_i   = 1'b1;
          state_next = S_BND_EVAL;
        end
      end
      S_BND_EVAL: begin
        cmd.bnd_acc = 1'b1;
        state_next  = S_BND_CHK;
      end
      S_READ_WAIT: begin
        cmd.read_cap = 1'b1;
        state_next   = S_FIN;
      end
      S_RM_RD: begin
        cmd.rd_last = 1'b1;
        state_next  = S_RM_WR;
      end
      S_RM_WR: begin
        cmd.wr_rm = 1'b1;
        case (status.mode)
          MODE_ADD:  state_next = S_ADD_CHK;
          MODE_SUB:  state_next = S_SUB_CHK;
          MODE_CLIP: state_next = S_CLIP_CHK;
          default:   state_next = S_FIN;
        endcase
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### design/drse_datapath.sv
// Datapath: operand, scan registers, store and pending-stack RAMs, geometry.
// Depends on drse_pkg and drse_ram; commanded by drse_ctrl.
`default_nettype none
module drse_datapath #(
  parameter int CAPACITY      = drse_pkg::CAPACITY_DEF,
  parameter int PENDING_DEPTH = drse_pkg::PENDING_DEPTH_DEF,
  parameter int COORD_BITS    = drse_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  drse_pkg::cmd_t                      cmd,
  output drse_pkg::status_t                   status,
  input  logic [drse_pkg::MODE_BITS-1:0]      mode,
  input  logic signed [COORD_BITS-1:0]        rect_x,
  input  logic signed [COORD_BITS-1:0]        rect_y,
  input  logic [COORD_BITS-2:0]               rect_w,
  input  logic [COORD_BITS-2:0]               rect_h,
  input  logic [$clog2(CAPACITY)-1:0]         entry_index,
  output logic signed [COORD_BITS-1:0]        out_x,
  output logic signed [COORD_BITS-1:0]        out_y,
  output logic [COORD_BITS-1:0]               out_w,
  output logic [COORD_BITS-1:0]               out_h,
  output logic                                out_found,
  output logic [$clog2(CAPACITY+1)-1:0]       entry_count,
  output logic                                overflow
);
  import drse_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PAW = $clog2(PENDING_DEPTH);
  localparam int PTW = $clog2(PENDING_DEPTH + 1);
  localparam int BW  = 4 * CB;
  localparam int PW  = BW + CW;
  localparam logic signed [CB:0] HI = (CB+1)'((2 ** (CB - 1)) - 1);
  localparam logic [CW-1:0]  CAP_C = CW'(CAPACITY);
  localparam logic [PTW-1:0] PD_C  = PTW'(PENDING_DEPTH);

  // operand, as edges
  logic [MODE_BITS-1:0] omode;
  logic [AW-1:0]        oidx;
  logic signed [CB-1:0] ox0, oy0, ox1, oy1;
  logic signed [CB:0]   sum_x, sum_y;
  logic signed [CB-1:0] sat_x1, sat_y1;

  // scan state
  logic signed [CB-1:0] cx0, cy0, cx1, cy1;
  logic [CW-1:0]        i, count;
  logic [PTW-1:0]       top;
  logic [1:0]           k;
  logic                 ovf;
  logic signed [CB-1:0] rx0, ry0, rx1, ry1;
  logic                 found;

  // RAM ports
  logic          s_we, s_re;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [BW-1:0] s_wdata, s_rdata;
  logic          p_we, p_re;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [PW-1:0] p_wdata, p_rdata;

  // stored entry under test
  logic signed [CB-1:0] px0, py0, px1, py1;

  // add decision
  logic nov, enclosed, covers, trim_ok, extra, split, lowonly;
  logic signed [CB-1:0] tx0, ty0, tx1, ty1;
  logic signed [CB-1:0] nx0, ny0, nx1, ny1;
  logic signed [CB-1:0] xx0, xy0, xx1, xy1, ymin;
  add_act_t act;

  // subtract / clip
  logic ovl, cov, piece_ok;
  logic signed [CB-1:0] vtop, vbot;
  logic [BW-1:0] piece;
  logic signed [CB-1:0] ix0, iy0, ix1, iy1;

  logic full, pfull, do_push;
  logic [BW-1:0] push_data;

  assign sum_x  = {rect_x[CB-1], rect_x} + {2'b00, rect_w};
  assign sum_y  = {rect_y[CB-1], rect_y} + {2'b00, rect_h};
  assign sat_x1 = (sum_x > HI) ? HI[CB-1:0] : sum_x[CB-1:0];
  assign sat_y1 = (sum_y > HI) ? HI[CB-1:0] : sum_y[CB-1:0];

  assign px0 = s_rdata[4*CB-1:3*CB];
  assign py0 = s_rdata[3*CB-1:2*CB];
  assign px1 = s_rdata[2*CB-1:CB];
  assign py1 = s_rdata[CB-1:0];

  assign full  = (count >= CAP_C);
  assign pfull = (top >= PD_C);

  // add: classify the current piece against one stored entry
  always_comb begin
    nov      = (cx0 >= px1) || (cx1 <= px0) || (cy0 >= py1) || (cy1 <= py0);
    enclosed = (cx0 >= px0) && (cx1 <= px1) && (cy0 >= py0) && (cy1 <= py1);
    covers   = (cx0 <= px0) && (cx1 >= px1) && (cy0 <= py0) && (cy1 >= py1);

    tx0 = px0; ty0 = py0; tx1 = px1; ty1 = py1;
    trim_ok = 1'b0;
    if ((cx0 <= px0) && (cx1 >= px1)) begin
      if ((cy0 <= py0) && (cy1 > py0)) begin
        ty0 = cy1; trim_ok = 1'b1;
      end else if ((cy0 < py1) && (cy1 >= py1)) begin
        ty1 = cy0; trim_ok = 1'b1;
      end
    end else if ((cy0 <= py0) && (cy1 >= py1)) begin
      if ((cx0 <= px0) && (cx1 > px0)) begin
        tx0 = cx1; trim_ok = 1'b1;
      end else if ((cx0 < px1) && (cx1 >= px1)) begin
        tx1 = cx0; trim_ok = 1'b1;
      end
    end

    nx0 = cx0; ny0 = cy0; nx1 = cx1; ny1 = cy1;
    xx0 = '0; xy0 = '0; xx1 = '0; xy1 = '0;
    extra = 1'b0; split = 1'b0; lowonly = 1'b0;
    ymin = (cy1 < py1) ? cy1 : py1;
    if (cy0 < py0) begin
      extra = 1'b1;
      xx0 = cx0; xy0 = cy0; xx1 = cx1; xy1 = py0;
      ny0 = py0;
    end
    if (nx0 < px0) begin
      if (!extra) begin
        extra = 1'b1;
        xx0 = nx0; xy0 = ny0; xx1 = px0; xy1 = ymin;
      end else begin
        nx1 = px0; split = 1'b1;
      end
    end
    if (!split && (nx1 > px1)) begin
      if (!extra) begin
        extra = 1'b1;
        xx0 = px1; xy0 = ny0; xx1 = nx1; xy1 = ymin;
      end else begin
        nx0 = px1; split = 1'b1;
      end
    end
    if (!split && (ny1 > py1)) begin
      ny0 = py1;
      if (extra) begin
        split = 1'b1;
      end else begin
        lowonly = 1'b1;
      end
    end

    if (nov)           act = ACT_SKIP;
    else if (enclosed) act = ACT_DROP;
    else if (covers)   act = ACT_REMOVE;
    else if (trim_ok)  act = ACT_TRIM;
    else if (split)    act = ACT_DESCEND;
    else               act = ACT_NEXT;
  end

  // subtract and clip against the operand
  always_comb begin
    ovl  = (px0 < ox1) && (ox0 < px1) && (py0 < oy1) && (oy0 < py1);
    cov  = !((ox0 > px0) || (oy0 > py0) || (ox1 < px1) || (oy1 < py1));
    vtop = (py0 > oy0) ? py0 : oy0;
    vbot = (py1 < oy1) ? py1 : oy1;
    ix0  = (px0 > ox0) ? px0 : ox0;
    iy0  = vtop;
    ix1  = (px1 < ox1) ? px1 : ox1;
    iy1  = vbot;
    case (k)
      2'd0: begin
        piece_ok = (py0 < oy0);
        piece    = {px0, py0, px1, oy0};
      end
      2'd1: begin
        piece_ok = (px0 < ox0);
        piece    = {px0, vtop, ox0, vbot};
      end
      2'd2: begin
        piece_ok = (px1 > ox1);
        piece    = {ox1, vtop, px1, vbot};
      end
      default: begin
        piece_ok = (py1 > oy1);
        piece    = {px0, oy1, px1, py1};
      end
    endcase
  end

  // store and pending-stack RAM ports
  always_comb begin
    do_push   = cmd.push_cur || (cmd.sub_piece && piece_ok);
    push_data = cmd.push_cur ? {cx0, cy0, cx1, cy1} : piece;
    s_we    = 1'b0;
    s_waddr = i[AW-1:0];
    s_wdata = s_rdata;
    if (do_push) begin
      s_we    = !full;
      s_waddr = count[AW-1:0];
      s_wdata = push_data;
    end else if (cmd.add_eval && (act == ACT_TRIM)) begin
      s_we    = 1'b1;
      s_wdata = {tx0, ty0, tx1, ty1};
    end else if (cmd.clip_wr) begin
      s_we    = 1'b1;
      s_wdata = {ix0, iy0, ix1, iy1};
    end else if (cmd.wr_rm) begin
      s_we    = 1'b1;
    end
    s_re = cmd.rd_i || cmd.rd_idx || cmd.rd_last;
    if (cmd.rd_idx)       s_raddr = oidx;
    else if (cmd.rd_last) s_raddr = AW'(count - CW'(1));
    else                  s_raddr = i[AW-1:0];

    p_we    = cmd.add_eval && (act == ACT_DESCEND) && !pfull;
    p_waddr = top[PAW-1:0];
    p_wdata = {nx0, ny0, nx1, ny1, CW'(i + CW'(1))};
    p_re    = cmd.pop_rd;
    p_raddr = PAW'(top - PTW'(1));
  end

  drse_ram #(.WIDTH(BW), .DEPTH(CAPACITY)) u_store (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  drse_ram #(.WIDTH(PW), .DEPTH(PENDING_DEPTH)) u_pending (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      top   <= '0;
      ovf   <= 1'b0;
      i     <= '0;
      k     <= '0;
      found <= 1'b0;
    end else begin
      if (do_push) begin
        if (full) ovf <= 1'b1;
        else      count <= count + CW'(1);
      end else if (cmd.rd_last) begin
        count <= count - CW'(1);
      end
      if (cmd.add_eval && (act == ACT_DESCEND) && pfull) ovf <= 1'b1;

      if (cmd.start_add || cmd.clr_i) begin
        i <= '0;
      end else if (cmd.idx_to_i) begin
        i <= CW'(oidx);
      end else if (cmd.pop_load) begin
        i <= p_rdata[CW-1:0];
      end else if (cmd.inc_i || cmd.clip_wr || cmd.bnd_acc ||
                   (cmd.add_eval &&
                    (act inside {ACT_SKIP, ACT_TRIM, ACT_NEXT, ACT_DESCEND}))) begin
        i <= i + CW'(1);
      end

      if (cmd.start_add) begin
        top <= '0;
      end else if (cmd.pop_rd) begin
        top <= top - PTW'(1);
      end else if (p_we) begin
        top <= top + PTW'(1);
      end

      if (cmd.rd_i)           k <= '0;
      else if (cmd.sub_piece) k <= k + 2'd1;

      if (cmd.load)                          found <= 1'b0;
      else if (cmd.set_found || cmd.read_cap) found <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      omode <= mode;
      oidx  <= entry_index;
      ox0   <= rect_x;
      oy0   <= rect_y;
      ox1   <= sat_x1;
      oy1   <= sat_y1;
      rx0   <= '0; ry0 <= '0; rx1 <= '0; ry1 <= '0;
    end else if (cmd.read_cap || (cmd.bnd_acc && (i == '0))) begin
      rx0 <= px0; ry0 <= py0; rx1 <= px1; ry1 <= py1;
    end else if (cmd.bnd_acc) begin
      if (px0 < rx0) rx0 <= px0;
      if (py0 < ry0) ry0 <= py0;
      if (px1 > rx1) rx1 <= px1;
      if (py1 > ry1) ry1 <= py1;
    end

    if (cmd.start_add) begin
      cx0 <= ox0; cy0 <= oy0; cx1 <= ox1; cy1 <= oy1;
    end else if (cmd.pop_load) begin
      {cx0, cy0, cx1, cy1} <= p_rdata[PW-1:CW];
    end else if (cmd.add_eval && (act == ACT_NEXT)) begin
      if (lowonly) begin
        cx0 <= nx0; cy0 <= ny0; cx1 <= nx1; cy1 <= ny1;
      end else begin
        cx0 <= xx0; cy0 <= xy0; cx1 <= xx1; cy1 <= xy1;
      end
    end else if (cmd.add_eval && (act == ACT_DESCEND)) begin
      if (pfull) begin
        cx0 <= nx0; cy0 <= ny0; cx1 <= nx1; cy1 <= ny1;
      end else begin
        cx0 <= xx0; cy0 <= xy0; cx1 <= xx1; cy1 <= xy1;
      end
    end

    if (cmd.out_load) begin
      out_x       <= rx0;
      out_y       <= ry0;
      out_w       <= CB'(rx1 - rx0);
      out_h       <= CB'(ry1 - ry0);
      out_found   <= found;
      entry_count <= count;
      overflow    <= ovf;
    end
  end

  always_comb begin
    status            = '0;
    status.mode       = omode;
    status.op_empty   = !((ox1 > ox0) && (oy1 > oy0));
    status.i_end      = (i >= count);
    status.idx_ok     = (CW'(oidx) < count);
    status.top_zero   = (top == '0);
    status.count_zero = (count == '0);
    status.act        = act;
    status.ovl        = ovl;
    status.cov        = cov;
    status.k_last     = (k == PIECE_LAST);
  end

endmodule
`default_nettype wire

### design/dirty_rect_set_engine.sv
// Dirty rectangle set engine: bounded set of non-overlapping rectangles.
// One request in flight at a time. For add, subtract, clip and bounds the
// sequencer walks the store RAM (one write port, one read port) entry by
// entry, so the time taken grows with the entry count and, for add, with
// the pending pieces. Results sit in an output register so the next
// request is taken while one waits.
// Reset (rst, synchronous) empties the set and clears the overflow flag.
`default_nettype none
module dirty_rect_set_engine #(
  parameter int CAPACITY      = drse_pkg::CAPACITY_DEF,
  parameter int PENDING_DEPTH = drse_pkg::PENDING_DEPTH_DEF,
  parameter int COORD_BITS    = drse_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [drse_pkg::MODE_BITS-1:0]    mode,
  input  logic signed [COORD_BITS-1:0]      rect_x,
  input  logic signed [COORD_BITS-1:0]      rect_y,
  input  logic [COORD_BITS-2:0]             rect_w,
  input  logic [COORD_BITS-2:0]             rect_h,
  input  logic [$clog2(CAPACITY)-1:0]       entry_index,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output logic [COORD_BITS-1:0]             out_w,
  output logic [COORD_BITS-1:0]             out_h,
  output logic                              out_found,
  output logic [$clog2(CAPACITY+1)-1:0]     entry_count,
  output logic                              overflow
);
  import drse_pkg::*;

  // Sequencer and datapath talk only through these two bundles.
  cmd_t    cmd;
  status_t status;

  // The controller steps through each mode: reads an entry, lets the
  // datapath classify it, then writes back, trims, splits or removes.
  drse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath holds the store, the pending stack of split pieces for add,
  // the overflow flag and the result register.
  drse_datapath #(
    .CAPACITY      (CAPACITY),
    .PENDING_DEPTH (PENDING_DEPTH),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .mode        (mode),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_w      (rect_w),
    .rect_h      (rect_h),
    .entry_index (entry_index),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_w       (out_w),
    .out_h       (out_h),
    .out_found   (out_found),
    .entry_count (entry_count),
    .overflow    (overflow)
  );

endmodule
`default_nettype wire
